// ===== hw/rtl/rii_pkg.sv =====
// Shared types, constants and helper functions of the RGB integral image block.
package rii_pkg;

   // Field and accumulator widths
   localparam int GREY_W     = 8;
   localparam int COL_SUM_W  = 18;
   localparam int COL_SQ_W   = 27;
   localparam int ROW_SUM_W  = 28;
   localparam int ROW_SQ_W   = 37;
   localparam int OUT_SUM_W  = 28;
   localparam int OUT_SQ_W   = 36;
   localparam int COLOUR_W   = 8;
   localparam int SIZE_W     = 11;

   // Default sizes of the column store and the frame
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int SIZE_RESET     = 1024;

   // Register indexes of the configuration port
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Divide by three as multiply by 683 and shift by 11 (exact for sums up to 765)
   localparam int RECIP_THIRD = 683;
   localparam int RECIP_SHIFT = 11;

   // Item entering the column store stage
   typedef struct packed {
      logic              valid;
      logic              first_row;
      logic              first_col;
      logic              last;
      logic [GREY_W-1:0] grey;
   } pix_type;

   // Item leaving the column store stage
   typedef struct packed {
      logic                 valid;
      logic                 first_col;
      logic                 last;
      logic [COL_SUM_W-1:0] col_sum;
      logic [COL_SQ_W-1:0]  col_sq;
   } col_type;

   // Truncated mean of the three colour components
   function automatic logic [GREY_W-1:0] grey_of(input logic [COLOUR_W-1:0] red,
                                                 input logic [COLOUR_W-1:0] green,
                                                 input logic [COLOUR_W-1:0] blue);
      logic [9:0]  total;
      logic [19:0] scaled;
      total  = 10'(red) + 10'(green) + 10'(blue);
      scaled = 20'(total) * 20'(RECIP_THIRD);
      return scaled[RECIP_SHIFT +: GREY_W];
   endfunction

   // Index of the last row or column for a written size, clamped to 1..max
   function automatic logic [31:0] size_last(input logic [SIZE_W-1:0] value, input int max);
      logic [31:0] ext;
      ext = 32'(value);
      if (ext == 32'd0) begin
         return 32'd0;
      end
      if (ext > 32'(max)) begin
         return 32'(max) - 32'd1;
      end
      return ext - 32'd1;
   endfunction

endpackage

// ===== hw/rtl/rgb_integral_image.sv =====
// Top level of the RGB integral image block.
//
// Pixels arrive in raster order on the req_ stream, one item per pixel with
// red, green and blue in req_tdata. Each is reduced to a grey level and the
// block returns one rsp_ item per pixel: the inclusive integral-image sum and
// the inclusive sum of squared grey levels, with rsp_tlast on the last pixel
// of the frame. Frame size comes from the csr_ port (image width at index 0,
// image height at index 1); a size of 0 acts as 1, a size above the
// maximum acts as the maximum, and any write starts a new frame.
// A pixel's result passes the column store's stage and output registers,
// then the output register, before rsp_tvalid rises. One pixel is taken
// every cycle unless the output stalls, set by the single read-modify-write
// per cycle on the column store, forwarding when a column is hit twice in a row.
// Reset clears the pipeline and positions and restores both sizes to 1024
// (clamped to the maximum); the column store needs no clearing, since the
// first row of every frame overwrites it. When rsp_tready is low with a
// result waiting, the whole pipeline holds and req_tready drops.
module rgb_integral_image #(
   parameter int MAX_WIDTH  = rii_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rii_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: red [7:0], green [15:8], blue [23:16]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,
   // rsp_tdata: integral_sum [27:0], integral_square_sum [63:28]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_wen,
   input  logic [rii_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rii_pkg::SIZE_W-1:0]     csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] wlast_ff, wlast_in;
   logic [RW-1:0] hlast_ff, hlast_in;
   logic [31:0]   wlast_calc, hlast_calc, wlast_rst, hlast_rst;

   logic [rii_pkg::ROW_SUM_W-1:0] row_sum_ff, row_sum_in;
   logic [rii_pkg::ROW_SQ_W-1:0]  row_sq_ff, row_sq_in;
   logic                          rsp_valid_ff;
   logic [rii_pkg::OUT_SUM_W-1:0] rsp_sum_ff;
   logic [rii_pkg::OUT_SQ_W-1:0]  rsp_sq_ff;
   logic                          rsp_last_ff;

   logic             en;
   logic             accept;
   rii_pkg::pix_type pix;
   rii_pkg::col_type col;

   // Pipeline advances whenever the output register is free or being taken
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // Size registers hold the clamped last index
   assign wlast_calc = rii_pkg::size_last(csr_wdata, MAX_WIDTH);
   assign hlast_calc = rii_pkg::size_last(csr_wdata, MAX_HEIGHT);
   assign wlast_rst  = rii_pkg::size_last(rii_pkg::SIZE_W'(rii_pkg::SIZE_RESET), MAX_WIDTH);
   assign hlast_rst  = rii_pkg::size_last(rii_pkg::SIZE_W'(rii_pkg::SIZE_RESET), MAX_HEIGHT);

   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            rii_pkg::CSR_IMAGE_WIDTH:  wlast_in = wlast_calc[CW-1:0];
            rii_pkg::CSR_IMAGE_HEIGHT: hlast_in = hlast_calc[RW-1:0];
            default: ;
         endcase
      end
   end

   // Raster position of the next pixel
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (csr_wen) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = (row_ff == hlast_ff) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else begin
         col_in = col_ff;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         wlast_ff <= wlast_rst[CW-1:0];
         hlast_ff <= hlast_rst[RW-1:0];
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
      end
   end

   // Grey level and position flags of the incoming pixel
   always_comb begin
      pix.valid     = accept;
      pix.first_row = (row_ff == '0);
      pix.first_col = (col_ff == '0);
      pix.last      = (col_ff == wlast_ff) && (row_ff == hlast_ff);
      pix.grey      = rii_pkg::grey_of(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
   end

   rii_column_acc #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (CW)
   ) u_column_acc (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_item  (pix),
      .in_addr  (col_ff),
      .out_item (col)
   );

   // Running sums along the row, restarted at column zero
   always_comb begin
      if (col.first_col) begin
         row_sum_in = rii_pkg::ROW_SUM_W'(col.col_sum);
         row_sq_in  = rii_pkg::ROW_SQ_W'(col.col_sq);
      end else begin
         row_sum_in = row_sum_ff + rii_pkg::ROW_SUM_W'(col.col_sum);
         row_sq_in  = row_sq_ff + rii_pkg::ROW_SQ_W'(col.col_sq);
      end
   end

   always_ff @(posedge clock) begin
      if (en && col.valid) begin
         row_sum_ff  <= row_sum_in;
         row_sq_ff   <= row_sq_in;
         rsp_sum_ff  <= row_sum_in;
         rsp_sq_ff   <= row_sq_in[rii_pkg::OUT_SQ_W-1:0];
         rsp_last_ff <= col.last;
      end
   end

   // Output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= col.valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sq_ff, rsp_sum_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/rii_column_acc.sv =====
// Column store stage: reads, updates and writes back the per-column running sums.
module rii_column_acc #(
   parameter int DEPTH  = rii_pkg::DEF_MAX_WIDTH,
   parameter int ADDR_W = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  rii_pkg::pix_type     in_item,
   input  logic [ADDR_W-1:0]    in_addr,
   output rii_pkg::col_type     out_item
);

   localparam int ENTRY_W = rii_pkg::COL_SUM_W + rii_pkg::COL_SQ_W;

   // Column sums, grey total in the low bits, squared total above
   logic [ENTRY_W-1:0] mem [DEPTH];

   rii_pkg::pix_type    s1_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [ENTRY_W-1:0]  rdata_ff;
   logic                fwd_ff;
   logic [ENTRY_W-1:0]  fwd_data_ff;
   rii_pkg::col_type    out_ff;

   logic [ENTRY_W-1:0]           base;
   logic [15:0]                  grey_sq;
   logic [rii_pkg::COL_SUM_W-1:0] new_sum;
   logic [rii_pkg::COL_SQ_W-1:0]  new_sq;
   logic                         addr_hit;

   // Old column value: zero on the first row, forwarded when the previous item hit it
   always_comb begin
      if (s1_ff.first_row) begin
         base = '0;
      end else if (fwd_ff) begin
         base = fwd_data_ff;
      end else begin
         base = rdata_ff;
      end
      grey_sq = 16'(s1_ff.grey) * 16'(s1_ff.grey);
      new_sum = base[rii_pkg::COL_SUM_W-1:0] + rii_pkg::COL_SUM_W'(s1_ff.grey);
      new_sq  = base[ENTRY_W-1:rii_pkg::COL_SUM_W] + rii_pkg::COL_SQ_W'(grey_sq);
   end

   // Same column read in the cycle it is written back (one-pixel rows)
   assign addr_hit = s1_ff.valid && (s1_addr_ff == in_addr);

   // Memory: read for the incoming item, write back for the item in this stage
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= mem[in_addr];
         if (s1_ff.valid) begin
            mem[s1_addr_ff] <= {new_sq, new_sum};
         end
      end
   end

   // Stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         fwd_ff       <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff              <= in_item;
         s1_addr_ff         <= in_addr;
         fwd_ff             <= addr_hit;
         fwd_data_ff        <= {new_sq, new_sum};
         out_ff.valid       <= s1_ff.valid;
         out_ff.first_col   <= s1_ff.first_col;
         out_ff.last        <= s1_ff.last;
         out_ff.col_sum     <= new_sum;
         out_ff.col_sq      <= new_sq;
      end
   end

   assign out_item = out_ff;

endmodule

// ===== hw/rtl/rii_checker.sv =====
// Port-level checks of the RGB integral image block, bound to the top level.
module rii_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input is only refused while a result waits on the receiver
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused without output stall");

   // With the receiver ready, an accepted item passes the pipeline and shows up as a valid result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing three cycles after input item");

endmodule

bind rgb_integral_image rii_checker u_rii_checker (.*);

// ===== bench/rgb_integral_image_test.sv =====
// Self-checking testbench for the RGB integral image block: directed table, then random frames.
`timescale 1ns / 100ps

module rgb_integral_image_test;

   localparam int MAX_COLS     = rii_pkg::DEF_MAX_WIDTH;
   localparam int MAX_ROWS     = rii_pkg::DEF_MAX_HEIGHT;
   localparam int RANDOM_ITEMS = 1250;
   localparam int CALM_ITEMS   = 150;
   localparam int WIDE_ROW_AT  = 0;
   localparam int END_CYCLES   = 8;

   // Expected sums of one pixel
   typedef struct packed {
      logic [rii_pkg::OUT_SUM_W-1:0] sum;
      logic [rii_pkg::OUT_SQ_W-1:0]  square;
      logic                          last;
   } pixel_sums_type;

   // One row of the directed table
   typedef enum logic [1:0] {ROW_PIXEL, ROW_WIDTH, ROW_HEIGHT} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [rii_pkg::SIZE_W-1:0] value;
      logic [7:0]                 red;
      logic [7:0]                 green;
      logic [7:0]                 blue;
      bit                         typed;
      pixel_sums_type             sums;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [23:0]                    req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [63:0]                    rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_wen;
   logic [rii_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [rii_pkg::SIZE_W-1:0]     csr_wdata;

   // Own copy of the block's state
   logic [rii_pkg::SIZE_W-1:0]    width_reg;
   logic [rii_pkg::SIZE_W-1:0]    height_reg;
   logic [rii_pkg::COL_SUM_W-1:0] column_grey [MAX_COLS];
   logic [rii_pkg::COL_SQ_W-1:0]  column_square [MAX_COLS];
   logic [rii_pkg::ROW_SUM_W-1:0] run_sum;
   logic [rii_pkg::ROW_SQ_W-1:0]  run_square;
   int unsigned                   col_at;
   int unsigned                   row_at;

   pixel_sums_type pending_sums[$];
   stim_row_type   directed_rows[$];
   int             fail_count;
   int             random_count;
   bit             sender_idles;
   bit             receiver_idles;
   bit             wide_row_done;

   rgb_integral_image dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Size in use: 0 acts as 1, anything above the maximum as the maximum
   function automatic int unsigned size_in_use(input logic [rii_pkg::SIZE_W-1:0] value,
                                               input int max);
      if (value == '0) begin
         return 1;
      end
      if (int'(value) > max) begin
         return max;
      end
      return int'(value);
   endfunction

   // Grey level, column and row accumulation for one pixel, then advance position
   function automatic pixel_sums_type integrate_pixel(input logic [23:0] colours);
      int unsigned w_use;
      int unsigned h_use;
      int unsigned c;
      int unsigned r;
      int unsigned grey;
      int unsigned square;
      pixel_sums_type res;
      w_use  = size_in_use(width_reg, MAX_COLS);
      h_use  = size_in_use(height_reg, MAX_ROWS);
      c      = (col_at >= w_use) ? 0 : col_at;
      r      = (row_at >= h_use) ? 0 : row_at;
      grey   = (32'(colours[7:0]) + 32'(colours[15:8]) + 32'(colours[23:16])) / 3;
      square = grey * grey;
      // first row of a frame overwrites the column totals
      if (r == 0) begin
         column_grey[c]   = rii_pkg::COL_SUM_W'(grey);
         column_square[c] = rii_pkg::COL_SQ_W'(square);
      end else begin
         column_grey[c]   = column_grey[c] + rii_pkg::COL_SUM_W'(grey);
         column_square[c] = column_square[c] + rii_pkg::COL_SQ_W'(square);
      end
      // first column of a row overwrites the row totals
      if (c == 0) begin
         run_sum    = rii_pkg::ROW_SUM_W'(column_grey[c]);
         run_square = rii_pkg::ROW_SQ_W'(column_square[c]);
      end else begin
         run_sum    = run_sum + rii_pkg::ROW_SUM_W'(column_grey[c]);
         run_square = run_square + rii_pkg::ROW_SQ_W'(column_square[c]);
      end
      res.sum    = run_sum;
      res.square = run_square[rii_pkg::OUT_SQ_W-1:0];
      res.last   = (c + 1 == w_use) && (r + 1 == h_use);
      c = c + 1;
      if (c >= w_use) begin
         c = 0;
         r = r + 1;
         if (r >= h_use) begin
            r = 0;
         end
      end
      col_at = c;
      row_at = r;
      return res;
   endfunction

   // Table builders
   function automatic stim_row_type pixel_row(input logic [7:0] red, green, blue);
      stim_row_type row;
      row       = '{kind: ROW_PIXEL, value: '0, red: red, green: green, blue: blue,
                    typed: 1'b0, sums: '0};
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [7:0] red, green, blue,
                                                input logic [rii_pkg::OUT_SUM_W-1:0] sum,
                                                input logic [rii_pkg::OUT_SQ_W-1:0] square,
                                                input logic last);
      stim_row_type row;
      row       = pixel_row(red, green, blue);
      row.typed = 1'b1;
      row.sums  = '{sum: sum, square: square, last: last};
      return row;
   endfunction

   function automatic stim_row_type size_row(input row_kind_type kind,
                                             input logic [rii_pkg::SIZE_W-1:0] value);
      stim_row_type row;
      row       = pixel_row(8'd0, 8'd0, 8'd0);
      row.kind  = kind;
      row.value = value;
      return row;
   endfunction

   function automatic logic [23:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return 24'($urandom);
      endcase
   endfunction

   // Send one pixel item; entered and left at a falling edge
   task automatic send_pixel(input logic [23:0] colours, input bit typed,
                             input pixel_sums_type typed_sums);
      pixel_sums_type predicted;
      if (csr_wen) begin
         csr_wen <= 1'b0;
      end
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= colours;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = integrate_pixel(colours);
      pending_sums.push_back(typed ? typed_sums : predicted);
      @(negedge clock);
   endtask

   task automatic send_random(input int count, input bit mostly_white);
      for (int i = 0; i < count && random_count < RANDOM_ITEMS; i++) begin
         // no idling on either side in the closing stretch
         if (random_count >= RANDOM_ITEMS - CALM_ITEMS) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         if (mostly_white && $urandom_range(0, 3) != 0) begin
            send_pixel('1, 1'b0, '0);
         end else begin
            send_pixel(random_pixel(), 1'b0, '0);
         end
         random_count++;
      end
   endtask

   // Hold the sender until every outstanding result has come back
   task automatic drain_results();
      if (pending_sums.size() != 0) begin
         req_tvalid <= 1'b0;
         while (pending_sums.size() != 0) begin
            @(negedge clock);
         end
      end
   endtask

   // Register write; leaves csr_wen high so back-to-back writes need no toggle
   task automatic write_csr(input logic [rii_pkg::CSR_ADDR_W-1:0] index,
                            input logic [rii_pkg::SIZE_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      if (index == rii_pkg::CSR_IMAGE_WIDTH) begin
         width_reg = value;
      end else begin
         height_reg = value;
      end
      col_at = 0;
      row_at = 0;
      @(negedge clock);
   endtask

   // Receiver: ready drops in random bursts while idling is on
   initial begin
      int stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin
      pixel_sums_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected result item: integral_sum %0d",
                   rsp_tdata[rii_pkg::OUT_SUM_W-1:0]);
            fail_count++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_tdata[rii_pkg::OUT_SUM_W-1:0] !== want.sum) begin
               $error("integral_sum expected %0d actual %0d",
                      want.sum, rsp_tdata[rii_pkg::OUT_SUM_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[rii_pkg::OUT_SUM_W +: rii_pkg::OUT_SQ_W] !== want.square) begin
               $error("integral_square_sum expected %0d actual %0d",
                      want.square, rsp_tdata[rii_pkg::OUT_SUM_W +: rii_pkg::OUT_SQ_W]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_frame expected %0d actual %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      int kind;
      int w;
      int h;
      int count;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_wen        = 1'b0;
      csr_addr       = rii_pkg::CSR_IMAGE_WIDTH;
      csr_wdata      = '0;
      fail_count     = 0;
      random_count   = 0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      wide_row_done  = 1'b0;
      width_reg      = rii_pkg::SIZE_W'(rii_pkg::SIZE_RESET);
      height_reg     = rii_pkg::SIZE_W'(rii_pkg::SIZE_RESET);
      run_sum        = '0;
      run_square     = '0;
      col_at         = 0;
      row_at         = 0;
      foreach (column_grey[i]) begin
         column_grey[i]   = '0;
         column_square[i] = '0;
      end

      // after reset: 1024 x 1024
      directed_rows.push_back(checked_row(8'd0, 8'd0, 8'd0, 28'd0, 36'd0, 1'b0));
      directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 28'd255, 36'd65025, 1'b0));
      // zero sizes act as one: every pixel is a whole frame
      directed_rows.push_back(size_row(ROW_WIDTH, 11'd0));
      directed_rows.push_back(size_row(ROW_HEIGHT, 11'd0));
      directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 28'd255, 36'd65025, 1'b1));
      directed_rows.push_back(checked_row(8'd1, 8'd1, 8'd0, 28'd0, 36'd0, 1'b1));
      directed_rows.push_back(checked_row(8'd2, 8'd2, 8'd1, 28'd1, 36'd1, 1'b1));
      directed_rows.push_back(checked_row(8'h55, 8'hAA, 8'h00, 28'd85, 36'd7225, 1'b1));
      directed_rows.push_back(checked_row(8'hAA, 8'h55, 8'hFF, 28'd170, 36'd28900, 1'b1));
      // 2 x 2 white frame, then wrap into a new frame
      directed_rows.push_back(size_row(ROW_WIDTH, 11'd2));
      directed_rows.push_back(size_row(ROW_HEIGHT, 11'd2));
      directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 28'd255, 36'd65025, 1'b0));
      directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 28'd510, 36'd130050, 1'b0));
      directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 28'd510, 36'd130050, 1'b0));
      directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 28'd1020, 36'd260100, 1'b1));
      directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 28'd255, 36'd65025, 1'b0));
      directed_rows.push_back(checked_row(8'd0, 8'd0, 8'd0, 28'd255, 36'd65025, 1'b0));
      // write in mid-frame restarts the frame
      directed_rows.push_back(size_row(ROW_HEIGHT, 11'd3));
      directed_rows.push_back(checked_row(8'd3, 8'd3, 8'd3, 28'd3, 36'd9, 1'b0));
      // oversized values clamp to the maximum
      directed_rows.push_back(size_row(ROW_WIDTH, 11'd2047));
      directed_rows.push_back(size_row(ROW_HEIGHT, 11'd2047));
      directed_rows.push_back(checked_row(8'd254, 8'd255, 8'd255, 28'd254, 36'd64516, 1'b0));
      directed_rows.push_back(pixel_row(8'd128, 8'd64, 8'd32));
      directed_rows.push_back(pixel_row(8'd17, 8'd200, 8'd99));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_PIXEL: begin
               send_pixel({directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red},
                          directed_rows[i].typed, directed_rows[i].sums);
            end
            ROW_WIDTH: begin
               drain_results();
               write_csr(rii_pkg::CSR_IMAGE_WIDTH, directed_rows[i].value);
            end
            default: begin
               drain_results();
               write_csr(rii_pkg::CSR_IMAGE_HEIGHT, directed_rows[i].value);
            end
         endcase
      end

      // random phases, each started from an idle block
      while (random_count < RANDOM_ITEMS) begin
         drain_results();
         if (!wide_row_done && random_count >= WIDE_ROW_AT) begin
            // at least one full row at the maximum width, mostly white
            wide_row_done = 1'b1;
            write_csr(rii_pkg::CSR_IMAGE_WIDTH,
                      rii_pkg::SIZE_W'($urandom_range(MAX_COLS, 2047)));
            write_csr(rii_pkg::CSR_IMAGE_HEIGHT, 11'd1);
            send_random(MAX_COLS + $urandom_range(0, 3), 1'b1);
         end else begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
               // well-formed frames of small size
               w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
               h = $urandom_range(1, 6);
               write_csr(rii_pkg::CSR_IMAGE_WIDTH, rii_pkg::SIZE_W'(w));
               write_csr(rii_pkg::CSR_IMAGE_HEIGHT, rii_pkg::SIZE_W'(h));
               count = w * h * $urandom_range(1, 2);
               send_random(count, $urandom_range(0, 3) == 0);
            end else if (kind == 6) begin
               // frame cut short; the next write lands mid-frame
               w = $urandom_range(1, 12);
               h = $urandom_range(2, 12);
               write_csr(rii_pkg::CSR_IMAGE_HEIGHT, rii_pkg::SIZE_W'(h));
               write_csr(rii_pkg::CSR_IMAGE_WIDTH, rii_pkg::SIZE_W'(w));
               send_random($urandom_range(1, w * h - 1), 1'b0);
            end else if (kind == 7) begin
               // out-of-range register values
               write_csr(rii_pkg::CSR_IMAGE_WIDTH, ($urandom_range(0, 1) == 0) ? 11'd0
                         : rii_pkg::SIZE_W'($urandom_range(MAX_COLS + 1, 2047)));
               write_csr(rii_pkg::CSR_IMAGE_HEIGHT, ($urandom_range(0, 1) == 0) ? 11'd0
                         : rii_pkg::SIZE_W'($urandom_range(MAX_ROWS + 1, 2047)));
               send_random($urandom_range(1, 30), 1'b0);
            end else if (kind == 8) begin
               // one register alone
               if ($urandom_range(0, 1) == 0) begin
                  write_csr(rii_pkg::CSR_IMAGE_WIDTH, rii_pkg::SIZE_W'($urandom_range(0, 12)));
               end else begin
                  write_csr(rii_pkg::CSR_IMAGE_HEIGHT, rii_pkg::SIZE_W'($urandom_range(0, 12)));
               end
               send_random($urandom_range(1, 30), 1'b0);
            end else begin
               // pause with no write: the frame carries on
               send_random($urandom_range(1, 20), 1'b0);
            end
         end
      end

      drain_results();
      repeat (END_CYCLES) @(negedge clock);
      if (pending_sums.size() != 0) begin
         $error("%0d expected results never arrived", pending_sums.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("rgb_integral_image_test passed");
      end else begin
         $display("rgb_integral_image_test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("rgb_integral_image_test failed");
      $finish;
   end

endmodule
